### rtl/core/ledc_pkg.sv
`default_nettype none

package ledc_pkg;

  localparam int unsigned LineMax = 32;
  localparam int unsigned AddrW   = $clog2(LineMax);
  localparam int unsigned FillW   = $clog2(LineMax + 1);

  localparam logic [7:0] KeyBs     = 8'h08;
  localparam logic [7:0] KeyLf     = 8'h0A;
  localparam logic [7:0] KeyCr     = 8'h0D;
  localparam logic [7:0] KeyCtlQ   = 8'h11;
  localparam logic [7:0] KeySpace  = 8'h20;
  localparam logic [7:0] KeyBSlash = 8'h5C;
  localparam logic [7:0] KeyDel    = 8'h7F;

  localparam logic [7:0] AccQuote  = 8'h27;
  localparam logic [7:0] AccComma  = 8'h2C;
  localparam logic [7:0] AccColon  = 8'h3A;
  localparam logic [7:0] AccCaret  = 8'h5E;
  localparam logic [7:0] AccGrave  = 8'h60;
  localparam logic [7:0] AccTilde  = 8'h7E;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_EMIT,
    ST_LINE
  } ledc_state_e;

  function automatic logic is_dead_key(input logic [7:0] c);
    return (c == AccQuote) || (c == AccComma) || (c == AccColon) ||
           (c == AccCaret) || (c == AccGrave) || (c == AccTilde);
  endfunction

  // Returns {hit, composed Latin-1 code} for an accent and a letter.
  function automatic logic [8:0] compose(input logic [7:0] acc, input logic [7:0] key);
    logic [8:0] r;
    r = 9'h000;
    case ({acc, key})
      {AccTilde, 8'h41}: r = {1'b1, 8'hC3};
      {AccTilde, 8'h61}: r = {1'b1, 8'hE3};
      {AccTilde, 8'h4F}: r = {1'b1, 8'hD5};
      {AccTilde, 8'h6F}: r = {1'b1, 8'hF5};
      {AccComma, 8'h43}: r = {1'b1, 8'hC7};
      {AccComma, 8'h63}: r = {1'b1, 8'hE7};
      {AccComma, 8'h7A}: r = {1'b1, 8'hDF};
      {AccQuote, 8'h41}: r = {1'b1, 8'hC1};
      {AccQuote, 8'h61}: r = {1'b1, 8'hE1};
      {AccQuote, 8'h45}: r = {1'b1, 8'hC9};
      {AccQuote, 8'h65}: r = {1'b1, 8'hE9};
      {AccQuote, 8'h49}: r = {1'b1, 8'hCD};
      {AccQuote, 8'h69}: r = {1'b1, 8'hED};
      {AccQuote, 8'h4F}: r = {1'b1, 8'hD3};
      {AccQuote, 8'h6F}: r = {1'b1, 8'hF3};
      {AccQuote, 8'h55}: r = {1'b1, 8'hDA};
      {AccQuote, 8'h75}: r = {1'b1, 8'hFA};
      {AccCaret, 8'h41}: r = {1'b1, 8'hC2};
      {AccCaret, 8'h61}: r = {1'b1, 8'hE2};
      {AccCaret, 8'h45}: r = {1'b1, 8'hCA};
      {AccCaret, 8'h65}: r = {1'b1, 8'hEA};
      {AccCaret, 8'h49}: r = {1'b1, 8'hCE};
      {AccCaret, 8'h69}: r = {1'b1, 8'hEE};
      {AccCaret, 8'h4F}: r = {1'b1, 8'hD4};
      {AccCaret, 8'h6F}: r = {1'b1, 8'hF4};
      {AccCaret, 8'h55}: r = {1'b1, 8'hDB};
      {AccCaret, 8'h75}: r = {1'b1, 8'hFB};
      {AccGrave, 8'h41}: r = {1'b1, 8'hC0};
      {AccGrave, 8'h61}: r = {1'b1, 8'hE0};
      {AccGrave, 8'h45}: r = {1'b1, 8'hC8};
      {AccGrave, 8'h65}: r = {1'b1, 8'hE8};
      {AccGrave, 8'h49}: r = {1'b1, 8'hCC};
      {AccGrave, 8'h69}: r = {1'b1, 8'hEC};
      {AccGrave, 8'h4F}: r = {1'b1, 8'hD2};
      {AccGrave, 8'h6F}: r = {1'b1, 8'hF2};
      {AccGrave, 8'h55}: r = {1'b1, 8'hD9};
      {AccGrave, 8'h75}: r = {1'b1, 8'hF9};
      {AccColon, 8'h41}: r = {1'b1, 8'hC4};
      {AccColon, 8'h61}: r = {1'b1, 8'hE4};
      {AccColon, 8'h45}: r = {1'b1, 8'hCB};
      {AccColon, 8'h65}: r = {1'b1, 8'hEB};
      {AccColon, 8'h49}: r = {1'b1, 8'hCF};
      {AccColon, 8'h69}: r = {1'b1, 8'hEF};
      {AccColon, 8'h4F}: r = {1'b1, 8'hD6};
      {AccColon, 8'h6F}: r = {1'b1, 8'hF6};
      {AccColon, 8'h55}: r = {1'b1, 8'hDC};
      {AccColon, 8'h75}: r = {1'b1, 8'hFC};
      default:           r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ledc_ram.sv
`default_nettype none

module ledc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/line_editor_dead_key_compose.sv
// Line editor with dead-key accent composition.
//
// Keyboard bytes come in on the s_axis channel, one byte per transfer. Echo
// characters and the bytes of a finished line leave on the m_axis channel;
// tuser[0] is 0 for an echo and 1 for a line byte, tuser[1] marks the newline
// that ends a line, and tlast marks the last result of each key.
//
// An accepted key is decoded in the following cycle. CR or LF walks the line
// store through its single read port, one byte a cycle while the receiver
// keeps up. The line store is a 32 x 8 RAM with registered read.
//
// The result register lets the next key be accepted while the last result of
// the previous key still waits. When the receiver stalls, the block holds its
// work and its read pointer until the result register drains.
// After reset the line is empty and no accent is pending; the store needs no
// clearing, since only entries below the fill count are ever read.
`default_nettype none

module line_editor_dead_key_compose
  import ledc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] key_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic      [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic      [1:0] m_axis_tuser_o,   // [0] kind, [1] line_done
  output logic            m_axis_tlast_o
);

  ledc_state_e state_q, state_d;

  logic [7:0]       key_q;
  logic [7:0]       pend_q, pend_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] idx_q, idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic [7:0]       seq_b0_q, seq_b0_d, seq_b1_q, seq_b1_d;
  logic             seq_two_q, seq_two_d;

  logic             m_valid_q;
  logic [7:0]       m_byte_q;
  logic             m_kind_q, m_done_q, m_last_q;

  logic             push;
  logic [7:0]       push_byte;
  logic             push_kind, push_done, push_last;

  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata;

  logic             out_free;
  logic             s_xfer;
  logic [8:0]       lookup;
  logic             pend_any, act_ctlq, act_swallow, act_compose, plain;
  logic             key_eol, key_erase, act_eol, act_erase, act_store;
  logic             needs_out, work_go, line_end;
  logic             rd_load, rd_issue;
  logic [FillW-1:0] fill_dec;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_xfer   = s_axis_tvalid_i && s_axis_tready_o;

  assign lookup      = compose(pend_q, key_q);
  assign pend_any    = (pend_q != 8'h00);
  assign act_ctlq    = (key_q == KeyCtlQ);
  assign act_swallow = !act_ctlq && pend_any && (key_q == KeyBSlash);
  assign act_compose = !act_ctlq && pend_any && lookup[8];
  assign plain       = !act_ctlq && !act_swallow && !act_compose;
  assign key_eol     = (key_q == KeyLf) || (key_q == KeyCr);
  assign key_erase   = (key_q == KeyBs) || (key_q == KeyDel);
  assign act_eol     = plain && key_eol;
  assign act_erase   = plain && key_erase && (fill_q != '0);
  assign act_store   = plain && !key_eol && !key_erase && (fill_q < FillW'(LineMax));
  assign needs_out   = act_compose || act_erase || act_store;
  assign work_go     = !needs_out || out_free;
  assign fill_dec    = fill_q - FillW'(1);

  // In the line walk, a fetched byte is handed on only when the result
  // register can take it; the RAM output holds until then.
  assign rd_load  = rd_pend_q && out_free;
  assign rd_issue = (idx_q < fill_q) && (!rd_pend_q || rd_load);
  assign line_end = !rd_pend_q && (idx_q == fill_q) && out_free;

  ledc_ram #(
    .Width(8),
    .Depth(LineMax)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (work_go) begin
          if (act_compose || act_erase) begin
            state_d = ST_EMIT;
          end else if (act_eol) begin
            state_d = ST_LINE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free && !seq_two_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_LINE: begin
        if (line_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    push      = 1'b0;
    push_byte = key_q;
    push_kind = 1'b0;
    push_done = 1'b0;
    push_last = 1'b0;
    pend_d    = pend_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    rd_pend_d = rd_pend_q;
    seq_b0_d  = seq_b0_q;
    seq_b1_d  = seq_b1_q;
    seq_two_d = seq_two_q;
    we        = 1'b0;
    waddr     = fill_q[AddrW-1:0];
    wdata     = key_q;
    re        = 1'b0;
    raddr     = idx_q[AddrW-1:0];
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_WORK: begin
        if (work_go) begin
          if (!act_ctlq) begin
            pend_d = 8'h00;
          end
          if (act_compose) begin
            we        = (fill_q != '0);
            waddr     = fill_dec[AddrW-1:0];
            wdata     = lookup[7:0];
            push      = 1'b1;
            push_byte = KeyBs;
            seq_b0_d  = lookup[7:0];
            seq_two_d = 1'b0;
          end else if (act_eol) begin
            idx_d     = '0;
            rd_pend_d = 1'b0;
          end else if (act_erase) begin
            fill_d    = fill_dec;
            push      = 1'b1;
            push_byte = KeyBs;
            seq_b0_d  = KeySpace;
            seq_b1_d  = KeyBs;
            seq_two_d = 1'b1;
          end else if (act_store) begin
            we        = 1'b1;
            fill_d    = fill_q + FillW'(1);
            push      = 1'b1;
            push_last = 1'b1;
            if (is_dead_key(key_q)) begin
              pend_d = key_q;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          push      = 1'b1;
          push_byte = seq_b0_q;
          push_last = !seq_two_q;
          seq_b0_d  = seq_b1_q;
          seq_two_d = 1'b0;
        end
      end
      ST_LINE: begin
        if (rd_load) begin
          push      = 1'b1;
          push_byte = rdata;
          push_kind = 1'b1;
          rd_pend_d = 1'b0;
        end
        if (rd_issue) begin
          re        = 1'b1;
          idx_d     = idx_q + FillW'(1);
          rd_pend_d = 1'b1;
        end
        if (line_end) begin
          push      = 1'b1;
          push_byte = KeyLf;
          push_done = 1'b1;
          push_last = 1'b1;
          fill_d    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 8'h00;
      fill_q    <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      seq_two_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      rd_pend_q <= rd_pend_d;
      seq_two_q <= seq_two_d;
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      key_q <= s_axis_tdata_i;
    end
    seq_b0_q <= seq_b0_d;
    seq_b1_q <= seq_b1_d;
    if (push) begin
      m_byte_q <= push_byte;
      m_kind_q <= push_kind;
      m_done_q <= push_done;
      m_last_q <= push_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_byte_q;
  assign m_axis_tuser_o  = {m_done_q, m_kind_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

### rtl/core/ledc_checker.sv
`default_nettype none

module ledc_checker
  import ledc_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [1:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  // The newline that ends a line is always the final echo of its key.
  a_line_done_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |->
      m_axis_tlast_o && !m_axis_tuser_o[0] && (m_axis_tdata_o == KeyLf))
    else $error("line_done result is not a final newline echo");

  // A stored line byte is always followed by more output of the same key.
  a_line_byte_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tlast_o)
    else $error("line byte marked as last result");

  // A key is taken one at a time: ready drops right after a transfer.
  a_one_key_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("stalled result changed");

endmodule

bind line_editor_dead_key_compose ledc_checker u_ledc_checker (.*);

`default_nettype wire

### tb/sv/line_editor_dead_key_compose_tb.sv
module line_editor_dead_key_compose_tb;
  import ledc_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 300;

  localparam logic [47:0] DEAD_KEYS =
    {AccQuote, AccComma, AccColon, AccCaret, AccGrave, AccTilde};
  localparam logic [8*13-1:0] BASE_LETTERS = "AEIOUaeiouCcz";

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       done;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] key;
    logic       typed;
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
    out_t       r2;
  } row_t;

  localparam out_t NO_OUT = '0;
  localparam out_t BS_MID = {KeyBs, 1'b0, 1'b0, 1'b0};
  localparam out_t SP_MID = {KeySpace, 1'b0, 1'b0, 1'b0};
  localparam out_t BS_END = {KeyBs, 1'b0, 1'b0, 1'b1};
  localparam out_t NL_END = {KeyLf, 1'b0, 1'b1, 1'b1};

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tready;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // Editor state as the block should hold it.
  logic [7:0] ed_accent;
  logic [7:0] ed_line [0:LineMax-1];
  int         ed_fill;

  out_t key_out_q [$];
  out_t out_due_q [$];
  row_t dir_q [$];

  int errors = 0;
  int cycle_cnt = 0;
  int keys_sent = 0;
  int hold_req = 0;
  int snd_calm = 0;
  int rcv_calm = 0;

  line_editor_dead_key_compose dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("line_editor_dead_key_compose_tb NOT OK");
      $finish;
    end
  end

  // Latin-1 code for an accent and a letter, hit flag in bit 8. Vowel rows run
  // grave, acute, circumflex, then tilde or diaeresis; lower case is 0x20 up.
  function automatic logic [8:0] accented(input logic [7:0] acc, input logic [7:0] key);
    logic [7:0] up;
    logic [7:0] base;
    logic [7:0] off;
    logic       lower;
    logic       ok;
    lower = (key >= 8'h61) && (key <= 8'h7A);
    up    = lower ? key - 8'h20 : key;
    ok    = 1'b1;
    base  = 8'h00;
    off   = 8'h00;
    if (acc == AccComma) begin
      if (key == "z") return {1'b1, 8'hDF};
      if (up == "C") return {1'b1, lower ? 8'hE7 : 8'hC7};
      return 9'h000;
    end
    case (up)
      "A": base = 8'hC0;
      "E": base = 8'hC8;
      "I": base = 8'hCC;
      "O": base = 8'hD2;
      "U": base = 8'hD9;
      default: ok = 1'b0;
    endcase
    case (acc)
      AccGrave: off = 8'd0;
      AccQuote: off = 8'd1;
      AccCaret: off = 8'd2;
      AccTilde: begin
        off = 8'd3;
        ok  = ok && (up == "A" || up == "O");
      end
      AccColon: off = (up == "A" || up == "O") ? 8'd4 : 8'd3;
      default: ok = 1'b0;
    endcase
    if (!ok) return 9'h000;
    return {1'b1, base + off + (lower ? 8'h20 : 8'h00)};
  endfunction

  function automatic void add_out(input logic [7:0] d, input logic kind, input logic done);
    key_out_q.push_back({d, kind, done, 1'b0});
  endfunction

  function automatic void close_out();
    key_out_q[key_out_q.size()-1].last = 1'b1;
  endfunction

  // Applies one key to the editor state and leaves its results in key_out_q.
  function automatic void edit_key(input logic [7:0] key);
    logic [7:0] acc;
    logic [8:0] hit;
    key_out_q.delete();
    if (key == KeyCtlQ) return;
    if (ed_accent != 8'h00) begin
      acc       = ed_accent;
      ed_accent = 8'h00;
      if (key == KeyBSlash) return;
      hit = accented(acc, key);
      if (hit[8]) begin
        if (ed_fill > 0) ed_line[ed_fill-1] = hit[7:0];
        add_out(KeyBs, 1'b0, 1'b0);
        add_out(hit[7:0], 1'b0, 1'b0);
        close_out();
        return;
      end
    end
    if (key == KeyLf || key == KeyCr) begin
      for (int i = 0; i < ed_fill; i++) add_out(ed_line[i], 1'b1, 1'b0);
      add_out(KeyLf, 1'b0, 1'b1);
      ed_fill = 0;
      close_out();
      return;
    end
    if (key == KeyBs || key == KeyDel) begin
      if (ed_fill == 0) return;
      ed_fill--;
      add_out(KeyBs, 1'b0, 1'b0);
      add_out(KeySpace, 1'b0, 1'b0);
      add_out(KeyBs, 1'b0, 1'b0);
      close_out();
      return;
    end
    if (ed_fill >= LineMax) return;
    if (key inside {AccQuote, AccComma, AccColon, AccCaret, AccGrave, AccTilde})
      ed_accent = key;
    ed_line[ed_fill] = key;
    ed_fill++;
    add_out(key, 1'b0, 1'b0);
    close_out();
  endfunction

  function automatic row_t by_model(input logic [7:0] key);
    return {key, 1'b0, 2'd0, NO_OUT, NO_OUT, NO_OUT};
  endfunction

  function automatic row_t fixed_row(input logic [7:0] key, input logic [1:0] n,
                                     input out_t a, input out_t b, input out_t c);
    return {key, 1'b1, n, a, b, c};
  endfunction

  function automatic out_t lone_echo(input logic [7:0] d);
    return {d, 1'b0, 1'b0, 1'b1};
  endfunction

  // Offers one key and, once it is transferred, queues the results it is due
  // to cause: typed in for fixed rows, from the editor state otherwise.
  task automatic send_key(input row_t r, input bit rush);
    int gap;
    if (rush) begin
      gap = 0;
    end else if (snd_calm > 0) begin
      snd_calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      snd_calm = 20;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
    end
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= r.key;
    do @(posedge clk_i); while (!s_tready);
    edit_key(r.key);
    if (r.typed) begin
      if (r.n > 0) out_due_q.push_back(r.r0);
      if (r.n > 1) out_due_q.push_back(r.r1);
      if (r.n > 2) out_due_q.push_back(r.r2);
    end else begin
      foreach (key_out_q[i]) out_due_q.push_back(key_out_q[i]);
    end
    if (r.key != KeyCtlQ) keys_sent++;
  endtask

  function automatic logic [7:0] any_letter();
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_accent();
    return DEAD_KEYS[8*$urandom_range(0, 5) +: 8];
  endfunction

  // Result side: random stalls, one long hold on request, field checks.
  initial begin : drain
    int   stall;
    out_t got;
    out_t want;
    wait (rst_n);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else if (rcv_calm > 0) begin
        rcv_calm--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        rcv_calm = 25;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 17);
      end
      repeat (stall) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      got = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
      if (out_due_q.size() == 0) begin
        errors++;
        $display("%0t: transfer with nothing awaited: expected none, actual %h/%b/%b/%b",
                 $time, got.data, got.kind, got.done, got.last);
      end else begin
        want = out_due_q.pop_front();
        if (got !== want) begin
          errors++;
          if (got.data !== want.data)
            $display("%0t: out_byte expected %h actual %h", $time, want.data, got.data);
          if (got.kind !== want.kind)
            $display("%0t: kind expected %b actual %b", $time, want.kind, got.kind);
          if (got.done !== want.done)
            $display("%0t: line_done expected %b actual %b", $time, want.done, got.done);
          if (got.last !== want.last)
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        end
      end
    end
  end

  initial begin : stimulus
    int  n;
    int  fills;
    bit  held;
    bit  paused;
    logic [7:0] acc;

    ed_accent = 8'h00;
    ed_fill   = 0;
    fills     = 0;
    held      = 1'b0;
    paused    = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    dir_q.push_back(fixed_row(KeyBs, 2'd0, NO_OUT, NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row(KeyDel, 2'd0, NO_OUT, NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row(KeyCr, 2'd1, NL_END, NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row(KeyCtlQ, 2'd0, NO_OUT, NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row(8'h00, 2'd1, lone_echo(8'h00), NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row(8'hFF, 2'd1, lone_echo(8'hFF), NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row(AccTilde, 2'd1, lone_echo(AccTilde), NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row("A", 2'd2, BS_MID, lone_echo(8'hC3), NO_OUT));
    dir_q.push_back(fixed_row(AccComma, 2'd1, lone_echo(AccComma), NO_OUT, NO_OUT));
    dir_q.push_back(fixed_row("z", 2'd2, BS_MID, lone_echo(8'hDF), NO_OUT));
    dir_q.push_back(by_model(AccColon));
    dir_q.push_back(by_model("u"));
    dir_q.push_back(by_model(AccCaret));
    // A backslash right after an accent is swallowed.
    dir_q.push_back(fixed_row(KeyBSlash, 2'd0, NO_OUT, NO_OUT, NO_OUT));
    dir_q.push_back(by_model(AccGrave));
    // Ctrl-Q keeps the pending accent, so the next letter still composes.
    dir_q.push_back(fixed_row(KeyCtlQ, 2'd0, NO_OUT, NO_OUT, NO_OUT));
    dir_q.push_back(by_model("e"));
    dir_q.push_back(by_model(AccQuote));
    dir_q.push_back(by_model("x"));
    dir_q.push_back(fixed_row(KeyDel, 2'd3, BS_MID, SP_MID, BS_END));
    dir_q.push_back(by_model(KeyLf));
    dir_q.push_back(by_model(AccQuote));
    dir_q.push_back(by_model(KeyCr));
    dir_q.push_back(by_model(AccComma));
    dir_q.push_back(by_model(KeyBs));

    foreach (dir_q[i]) send_key(dir_q[i], 1'b0);

    keys_sent = 0;
    while (keys_sent < 145) begin
      if (!held && keys_sent >= 50) begin
        // The receiver holds off while keys keep coming, so the block backs up.
        held     = 1'b1;
        hold_req = LongHold;
        send_key(by_model(KeyCr), 1'b1);
        repeat (14) send_key(by_model(any_letter()), 1'b1);
      end
      if (!paused && keys_sent >= 110) begin
        paused = 1'b1;
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        while (out_due_q.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 6);
          repeat (n) send_key(by_model(any_letter()), 1'b0);
        end
        2, 3: begin
          send_key(by_model(any_accent()), 1'b0);
          if ($urandom_range(0, 3) == 0)
            send_key(by_model(any_letter()), 1'b0);
          else
            send_key(by_model(BASE_LETTERS[8*$urandom_range(0, 12) +: 8]), 1'b0);
        end
        4: begin
          n = $urandom_range(1, 3);
          repeat (n) send_key(by_model($urandom_range(0, 1) ? KeyBs : KeyDel), 1'b0);
        end
        5: send_key(by_model($urandom_range(0, 1) ? KeyCr : KeyLf), 1'b0);
        6: begin
          send_key(by_model(any_accent()), 1'b0);
          case ($urandom_range(0, 2))
            0: send_key(by_model(KeyBSlash), 1'b0);
            1: begin
              send_key(by_model(KeyCtlQ), 1'b0);
              send_key(by_model(BASE_LETTERS[8*$urandom_range(0, 12) +: 8]), 1'b0);
            end
            default: send_key(by_model(8'($urandom_range(0, 255))), 1'b0);
          endcase
        end
        7: send_key(by_model(8'($urandom_range(0, 255))), 1'b0);
        8: begin
          if (fills < 3) begin
            // Run the store past full, try an accent on the full line, then
            // end the line for the longest burst of results.
            fills++;
            repeat (LineMax + 2) send_key(by_model(any_letter()), 1'b0);
            acc = any_accent();
            send_key(by_model(acc), 1'b0);
            send_key(by_model("a"), 1'b0);
            send_key(by_model(KeyCr), 1'b0);
          end else begin
            send_key(by_model(any_letter()), 1'b0);
          end
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) send_key(by_model(any_letter()), 1'b0);
          send_key(by_model(KeyDel), 1'b0);
        end
      endcase
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (out_due_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0)
      $display("line_editor_dead_key_compose_tb OK");
    else
      $display("line_editor_dead_key_compose_tb NOT OK");
    $finish;
  end

endmodule
